FILE: design/gpthcrc_pkg.sv
package gpthcrc_pkg;

   localparam int unsigned MAX_HEADER_BYTES_DEF = 512;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

   // header layout, byte offsets
   localparam int unsigned MIN_HDR       = 92;
   localparam int unsigned SIZE_OFF      = 12;
   localparam int unsigned CRC_FIELD_OFF = 16;
   localparam int unsigned GUID_OFF      = 56;
   localparam int unsigned EACRC_OFF     = 88;

   localparam logic MODE_RESIGN  = 1'b0;
   localparam logic MODE_REFRESH = 1'b1;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE      = 8'd0,
      CSR_GUID_LOW  = 8'd1,
      CSR_GUID_HIGH = 8'd2,
      CSR_ENTRY_CRC = 8'd3
   } csr_index_type;

   localparam int unsigned RSP_FIFO_DEPTH = 4;

   typedef struct packed {
      logic        kind;
      logic [31:0] value;
      logic        status;
      logic        end_of_run;
   } rsp_type;

   // reflected CRC32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
      end
      return c;
   endfunction

endpackage

FILE: design/gpthcrc_rsp_fifo.sv
module gpthcrc_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_one,
   input  logic                 push_two,
   input  gpthcrc_pkg::rsp_type push_a,
   input  gpthcrc_pkg::rsp_type push_b,
   output logic                 space_two,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gpthcrc_pkg::rsp_type rsp_entry
);

   localparam int unsigned DEPTH = gpthcrc_pkg::RSP_FIFO_DEPTH;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   gpthcrc_pkg::rsp_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_b;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_entry = entry_ff[rd_ptr_ff];
   assign space_two = (count_ff <= CNT_W'(DEPTH - 2));
   assign wr_ptr_b  = wr_ptr_ff + PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_one) + PTR_W'(push_two);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_one) + CNT_W'(push_two) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_one) begin
         entry_ff[wr_ptr_ff] <= push_a;
      end
      if (push_two) begin
         entry_ff[wr_ptr_b] <= push_b;
      end
   end

endmodule

FILE: design/gpt_header_crc_refresh.sv
// Channel  Direction  Ports                                        Transfer when
// req      in         req_data_byte, req_last                      req_valid & req_ready
// rsp      out        rsp_kind, rsp_value, rsp_status, rsp_end_of_run  rsp_valid & rsp_ready
// csr      in         csr_index, csr_data                          csr_valid & csr_ready
//
// One header byte is taken per cycle while req_ready is high; its edit and
// CRC update are done at the req transfer and land in a four-entry result
// queue that feeds rsp. The last byte pushes two results (byte, CRC report),
// so it needs one extra rsp transfer; req_ready is low while the queue holds
// more than two results. csr_ready is always high. Reset is synchronous and
// clears run state, registers and the queue.
module gpt_header_crc_refresh #(
   parameter int unsigned MAX_HEADER_BYTES = gpthcrc_pkg::MAX_HEADER_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kind,
   output logic [31:0]                         rsp_value,
   output logic                                rsp_status,
   output logic                                rsp_end_of_run,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gpthcrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gpthcrc_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned OFF_W = $clog2(MAX_HEADER_BYTES + 1);
   localparam logic [OFF_W-1:0] OFF_MAX    = OFF_W'(MAX_HEADER_BYTES);
   localparam logic [OFF_W-1:0] OFF_SIZE   = OFF_W'(gpthcrc_pkg::SIZE_OFF);
   localparam logic [OFF_W-1:0] OFF_HCRC   = OFF_W'(gpthcrc_pkg::CRC_FIELD_OFF);
   localparam logic [OFF_W-1:0] OFF_GUID   = OFF_W'(gpthcrc_pkg::GUID_OFF);
   localparam logic [OFF_W-1:0] OFF_EACRC  = OFF_W'(gpthcrc_pkg::EACRC_OFF);
   localparam logic [OFF_W-1:0] OFF_MIN    = OFF_W'(gpthcrc_pkg::MIN_HDR);
   localparam logic [31:0]      MIN_HDR_32 = 32'(gpthcrc_pkg::MIN_HDR);

   // configuration
   logic        mode_ff;
   logic [63:0] guid_low_ff;
   logic [63:0] guid_high_ff;
   logic [31:0] entry_crc_ff;

   // run state
   logic [OFF_W-1:0] offset_ff, offset_in;
   logic [31:0]      decl_ff, decl_in;
   logic [31:0]      crc_run_ff, crc_run_in;
   logic [31:0]      crc_min_ff, crc_min_in;
   logic [31:0]      crc_decl_ff, crc_decl_in;

   logic [OFF_W-1:0] off;
   logic [7:0]       edited;
   logic             short_hdr;
   logic [31:0]      crc_sel;
   logic             accept;

   gpthcrc_pkg::rsp_type push_a, push_b, rsp_entry;

   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign off       = offset_ff;

   always_comb begin
      edited      = req_data_byte;
      offset_in   = offset_ff;
      decl_in     = decl_ff;
      crc_run_in  = crc_run_ff;
      crc_min_in  = crc_min_ff;
      crc_decl_in = crc_decl_ff;
      if (off < OFF_MAX) begin
         if (off >= OFF_SIZE && off < OFF_SIZE + OFF_W'(4)) begin
            decl_in = decl_ff | (32'(req_data_byte) << {off[1:0], 3'b000});
         end
         if (off >= OFF_HCRC && off < OFF_HCRC + OFF_W'(4)) begin
            edited = 8'h00;
         end else if (mode_ff == gpthcrc_pkg::MODE_RESIGN &&
                      off >= OFF_GUID && off < OFF_GUID + OFF_W'(8)) begin
            edited = guid_low_ff[{off[2:0], 3'b000} +: 8];
         end else if (mode_ff == gpthcrc_pkg::MODE_RESIGN &&
                      off >= OFF_GUID + OFF_W'(8) && off < OFF_GUID + OFF_W'(16)) begin
            edited = guid_high_ff[{off[2:0], 3'b000} +: 8];
         end else if (mode_ff == gpthcrc_pkg::MODE_REFRESH &&
                      off >= OFF_EACRC && off < OFF_EACRC + OFF_W'(4)) begin
            edited = entry_crc_ff[{off[1:0], 3'b000} +: 8];
         end
         crc_run_in = gpthcrc_pkg::crc_byte(crc_run_ff, edited);
         offset_in  = off + OFF_W'(1);
         if (offset_in == OFF_MIN) begin
            crc_min_in = crc_run_in;
         end
         if ({{(32-OFF_W){1'b0}}, offset_in} == decl_in) begin
            crc_decl_in = crc_run_in;
         end
      end
   end

   // report from the state as it stands after this byte
   always_comb begin
      short_hdr = (offset_in < OFF_MIN);
      if (decl_in >= MIN_HDR_32 && decl_in <= {{(32-OFF_W){1'b0}}, offset_in}) begin
         crc_sel = crc_decl_in;
      end else begin
         crc_sel = crc_min_in;
      end
      push_a.kind       = gpthcrc_pkg::KIND_BYTE;
      push_a.value      = 32'(edited);
      push_a.status     = gpthcrc_pkg::STATUS_OK;
      push_a.end_of_run = 1'b0;
      push_b.kind       = gpthcrc_pkg::KIND_REPORT;
      push_b.value      = short_hdr ? 32'h0 : ~crc_sel;
      push_b.status     = short_hdr ? gpthcrc_pkg::STATUS_SHORT : gpthcrc_pkg::STATUS_OK;
      push_b.end_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= '0;
         decl_ff     <= '0;
         crc_run_ff  <= gpthcrc_pkg::CRC_INIT;
         crc_min_ff  <= gpthcrc_pkg::CRC_INIT;
         crc_decl_ff <= gpthcrc_pkg::CRC_INIT;
      end else if (accept) begin
         if (req_last) begin
            offset_ff   <= '0;
            decl_ff     <= '0;
            crc_run_ff  <= gpthcrc_pkg::CRC_INIT;
            crc_min_ff  <= gpthcrc_pkg::CRC_INIT;
            crc_decl_ff <= gpthcrc_pkg::CRC_INIT;
         end else begin
            offset_ff   <= offset_in;
            decl_ff     <= decl_in;
            crc_run_ff  <= crc_run_in;
            crc_min_ff  <= crc_min_in;
            crc_decl_ff <= crc_decl_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= gpthcrc_pkg::MODE_RESIGN;
         guid_low_ff  <= '0;
         guid_high_ff <= '0;
         entry_crc_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gpthcrc_pkg::CSR_MODE:      mode_ff      <= csr_data[0];
            gpthcrc_pkg::CSR_GUID_LOW:  guid_low_ff  <= csr_data;
            gpthcrc_pkg::CSR_GUID_HIGH: guid_high_ff <= csr_data;
            gpthcrc_pkg::CSR_ENTRY_CRC: entry_crc_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   gpthcrc_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_one  (accept),
      .push_two  (accept && req_last),
      .push_a    (push_a),
      .push_b    (push_b),
      .space_two (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_entry (rsp_entry)
   );

   assign rsp_kind       = rsp_entry.kind;
   assign rsp_value      = rsp_entry.value;
   assign rsp_status     = rsp_entry.status;
   assign rsp_end_of_run = rsp_entry.end_of_run;

endmodule
